// ===== rtl/sha1_message_digest_assert.svh =====
// Assertion macros for the SHA-1 message digest block.
// Used by the top level only; no other dependencies.
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication under reset.
`define SHA1MD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha1md assertion failed");

// Next-cycle implication under reset.
`define SHA1MD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha1md assertion failed");

`else

`define SHA1MD_ASSERT_NOW(lbl, ante, cons)
`define SHA1MD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/sha1md_pkg.sv =====
// Types and constants for the SHA-1 message digest block.
// No dependencies; used by the round logic and the top level.
`timescale 1ns / 1ps

package sha1md_pkg;

    // Input transaction: one message byte or a finish request
    typedef struct packed {
        logic       req_type;
        logic [7:0] message_byte;
    } msg_item_t;

    // Output transaction: the five digest words
    typedef struct packed {
        logic [31:0] digest_word_0;
        logic [31:0] digest_word_1;
        logic [31:0] digest_word_2;
        logic [31:0] digest_word_3;
        logic [31:0] digest_word_4;
    } dig_item_t;

    // Five working or chaining words
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } work_t;

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    localparam int unsigned ROUNDS = 80;

    localparam work_t CV_INIT = '{
        a: 32'h67452301,
        b: 32'hEFCDAB89,
        c: 32'h98BADCFE,
        d: 32'h10325476,
        e: 32'hC3D2E1F0
    };

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    // Round constant by round index
    function automatic logic [31:0] round_k(input logic [6:0] rnd);
        logic [31:0] k;
        if (rnd < 7'd20) begin
            k = 32'h5A827999;
        end
        else if (rnd < 7'd40) begin
            k = 32'h6ED9EBA1;
        end
        else if (rnd < 7'd60) begin
            k = 32'h8F1BBCDC;
        end
        else begin
            k = 32'hCA62C1D6;
        end
        return k;
    endfunction

endpackage

// ===== rtl/sha1_message_digest.sv =====
// Append: a byte is taken while idle; the 64th byte of a block stalls the input
// through its compression (one round per cycle: 80 rounds plus the final add).
// Finish: padding is pushed one byte per cycle outside the compressions (9 to 72 bytes)
// with one or two compressions, then the digest is loaded into the output register.
// Input bytes are stalled while the single round unit compresses a block.
// Reset: chaining value to the initial constants, length zero, output empty.
`timescale 1ns / 1ps
`include "sha1_message_digest_assert.svh"

module sha1_message_digest (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   msg_valid,
    output logic                   msg_stall,
    input  sha1md_pkg::msg_item_t  msg_item,
    output logic                   dig_valid,
    input  logic                   dig_stall,
    output sha1md_pkg::dig_item_t  dig_item
);
    import sha1md_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PAD  = 2'd1;
    localparam logic [1:0] ST_COMP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [1:0] PH_MARK = 2'd0;
    localparam logic [1:0] PH_ZERO = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;

    localparam logic [6:0] LAST_RND = 7'(ROUNDS);

    logic [1:0]  state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic        fin_reg, fin_next;
    logic        last_reg, last_next;
    logic [63:0] len_reg, len_next;
    logic [63:0] bits_reg, bits_next;
    logic [23:0] word_reg, word_next;
    logic [6:0]  rnd_reg, rnd_next;
    work_t       cv_reg, cv_next;
    work_t       wk_reg, wk_next;
    logic        dig_valid_reg, dig_valid_next;
    dig_item_t   dig_reg, dig_next;

    logic [31:0] mem [16];
    logic [31:0] rd_data_reg;
    logic [3:0]  rd_addr;
    logic        mem_we;
    logic [3:0]  mem_waddr;
    logic [31:0] mem_wdata;

    logic [31:0] sched_reg [16];
    logic        sched_en;
    logic [31:0] w;
    work_t       round_out;

    logic        push_en;
    logic [7:0]  push_byte;
    logic [5:0]  pos;

    assign pos       = len_reg[5:0];
    assign msg_stall = (state_reg != ST_IDLE);
    assign dig_valid = dig_valid_reg;
    assign dig_item  = dig_reg;

    // Block buffer: one word per four bytes, registered read
    always_ff @(posedge clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Read ahead by one so round i sees word i
    assign rd_addr = (state_reg == ST_COMP) ? (rnd_reg[3:0] + 4'd1) : 4'd0;

    // Expand the message schedule from the sliding window
    assign w = (rnd_reg < 7'd16) ? rd_data_reg
             : {sched_reg[13][30:0] ^ sched_reg[8][30:0] ^ sched_reg[2][30:0]
                    ^ sched_reg[0][30:0],
                sched_reg[13][31] ^ sched_reg[8][31] ^ sched_reg[2][31]
                    ^ sched_reg[0][31]};

    assign sched_en = (state_reg == ST_COMP) && (rnd_reg < LAST_RND);

    // Advance the schedule window each round
    always_ff @(posedge clk) begin
        if (sched_en) begin
            for (int i = 0; i < 15; i++) begin
                sched_reg[i] <= sched_reg[i + 1];
            end
            sched_reg[15] <= w;
        end
    end

    sha1md_round u_round (
        .rnd    (rnd_reg),
        .w      (w),
        .wk_in  (wk_reg),
        .wk_out (round_out)
    );

    // Pick the byte to push: input byte or padding
    always_comb begin
        push_en   = 1'b0;
        push_byte = 8'h00;
        case (state_reg)
            ST_IDLE: begin
                if (msg_valid && (msg_item.req_type == REQ_APPEND)) begin
                    push_en   = 1'b1;
                    push_byte = msg_item.message_byte;
                end
            end
            ST_PAD: begin
                case (phase_reg)
                    PH_MARK: begin
                        push_en   = 1'b1;
                        push_byte = PAD_MARK;
                    end
                    PH_ZERO: begin
                        push_en   = (pos != LEN_OFFSET);
                        push_byte = 8'h00;
                    end
                    PH_LEN: begin
                        push_en   = 1'b1;
                        push_byte = bits_reg[63:56];
                    end
                    default: begin
                        push_en   = 1'b0;
                        push_byte = 8'h00;
                    end
                endcase
            end
            default: begin
                push_en   = 1'b0;
                push_byte = 8'h00;
            end
        endcase
    end

    // Sequencer and datapath next state
    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        fin_next       = fin_reg;
        last_next      = last_reg;
        len_next       = len_reg;
        bits_next      = bits_reg;
        word_next      = word_reg;
        rnd_next       = rnd_reg;
        cv_next        = cv_reg;
        wk_next        = wk_reg;
        dig_valid_next = dig_valid_reg;
        dig_next       = dig_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos[5:2];
        mem_wdata      = {word_reg, push_byte};

        // Drop the output once it is taken
        if (dig_valid_reg && !dig_stall) begin
            dig_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (msg_valid && (msg_item.req_type == REQ_FINISH)) begin
                    fin_next   = 1'b1;
                    last_next  = 1'b0;
                    bits_next  = {len_reg[60:0], 3'b000};
                    phase_next = PH_MARK;
                    state_next = ST_PAD;
                end
            end
            ST_PAD: begin
                case (phase_reg)
                    PH_MARK: begin
                        phase_next = PH_ZERO;
                    end
                    PH_ZERO: begin
                        if (pos == LEN_OFFSET) begin
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        bits_next = {bits_reg[55:0], 8'h00};
                        if (pos == 6'd63) begin
                            last_next = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = PH_MARK;
                    end
                endcase
            end
            ST_COMP: begin
                if (rnd_reg < LAST_RND) begin
                    wk_next  = round_out;
                    rnd_next = rnd_reg + 7'd1;
                end
                else begin
                    cv_next.a = cv_reg.a + wk_reg.a;
                    cv_next.b = cv_reg.b + wk_reg.b;
                    cv_next.c = cv_reg.c + wk_reg.c;
                    cv_next.d = cv_reg.d + wk_reg.d;
                    cv_next.e = cv_reg.e + wk_reg.e;
                    if (!fin_reg) begin
                        state_next = ST_IDLE;
                    end
                    else if (last_reg) begin
                        state_next = ST_EMIT;
                    end
                    else begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_EMIT: begin
                if (!dig_valid_reg || !dig_stall) begin
                    dig_next.digest_word_0 = cv_reg.a;
                    dig_next.digest_word_1 = cv_reg.b;
                    dig_next.digest_word_2 = cv_reg.c;
                    dig_next.digest_word_3 = cv_reg.d;
                    dig_next.digest_word_4 = cv_reg.e;
                    dig_valid_next = 1'b1;
                    cv_next        = CV_INIT;
                    len_next       = '0;
                    fin_next       = 1'b0;
                    last_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Pack the byte; store each full word; start compression on a full block
        if (push_en) begin
            len_next  = len_reg + 64'd1;
            word_next = {word_reg[15:0], push_byte};
            if (pos[1:0] == 2'd3) begin
                mem_we = 1'b1;
            end
            if (pos == 6'd63) begin
                state_next = ST_COMP;
                rnd_next   = '0;
                wk_next    = cv_reg;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_MARK;
            fin_reg       <= 1'b0;
            last_reg      <= 1'b0;
            len_reg       <= '0;
            rnd_reg       <= '0;
            cv_reg        <= CV_INIT;
            dig_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            fin_reg       <= fin_next;
            last_reg      <= last_next;
            len_reg       <= len_next;
            rnd_reg       <= rnd_next;
            cv_reg        <= cv_next;
            dig_valid_reg <= dig_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk) begin
        bits_reg <= bits_next;
        word_reg <= word_next;
        wk_reg   <= wk_next;
        dig_reg  <= dig_next;
    end

    `SHA1MD_ASSERT_NOW(a_rnd_range, state_reg == ST_COMP, rnd_reg <= LAST_RND)
    `SHA1MD_ASSERT_NOW(a_comp_aligned, (state_reg == ST_COMP) && (rnd_reg == 7'd0), pos == 6'd0)
    `SHA1MD_ASSERT_NOW(a_len_field, (state_reg == ST_PAD) && (phase_reg == PH_LEN), pos[5:3] == 3'b111)
    `SHA1MD_ASSERT_NEXT(a_emit_loads, (state_reg == ST_EMIT) && !(dig_valid_reg && dig_stall), dig_valid_reg && (state_reg == ST_IDLE))

endmodule

// ===== rtl/sha1md_round.sv =====
// One SHA-1 compression round: boolean function, constant, and word rotation.
// Depends on sha1md_pkg.
`timescale 1ns / 1ps

module sha1md_round (
    input  logic [6:0]      rnd,
    input  logic [31:0]     w,
    input  sha1md_pkg::work_t wk_in,
    output sha1md_pkg::work_t wk_out
);
    import sha1md_pkg::*;

    logic [31:0] f;
    logic [31:0] t;

    // Select the boolean function for this round group
    always_comb begin
        if (rnd < 7'd20) begin
            f = (wk_in.b & wk_in.c) | (~wk_in.b & wk_in.d);
        end
        else if (rnd < 7'd40) begin
            f = wk_in.b ^ wk_in.c ^ wk_in.d;
        end
        else if (rnd < 7'd60) begin
            f = (wk_in.b & wk_in.c) | (wk_in.b & wk_in.d) | (wk_in.c & wk_in.d);
        end
        else begin
            f = wk_in.b ^ wk_in.c ^ wk_in.d;
        end
    end

    // Sum and rotate the working words
    assign t = {wk_in.a[26:0], wk_in.a[31:27]} + f + wk_in.e + round_k(rnd) + w;

    assign wk_out.a = t;
    assign wk_out.b = wk_in.a;
    assign wk_out.c = {wk_in.b[1:0], wk_in.b[31:2]};
    assign wk_out.d = wk_in.c;
    assign wk_out.e = wk_in.d;

endmodule

// ===== bench/sha1_message_digest_tb.sv =====
// Self-checking testbench for the SHA-1 message digest block.
// Depends on sha1md_pkg and sha1_message_digest; it predicts each digest in SystemVerilog.
`timescale 1ns / 1ps

module sha1_message_digest_tb;
    import sha1md_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 300;
    localparam int PRINT_LIMIT = 40;

    localparam logic [31:0] K_CHOOSE = 32'h5A827999;
    localparam logic [31:0] K_PARITY_LO = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJORITY = 32'h8F1BBCDC;
    localparam logic [31:0] K_PARITY_HI = 32'hCA62C1D6;

    logic clk;
    logic rst_n;
    logic msg_valid;
    logic msg_stall;
    msg_item_t msg_item;
    logic dig_valid;
    logic dig_stall;
    dig_item_t dig_item;

    // Predicted hash state
    work_t chain;
    logic [7:0] block_bytes [64];
    logic [63:0] byte_count;
    dig_item_t pending_digests [$];

    // Traffic shaping and bookkeeping
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_off = 1'b0;
    int items_sent = 0;
    int digests_checked = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    sha1_message_digest u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg_item  (msg_item),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .dig_item  (dig_item)
    );

    initial
    begin : clock_gen
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Abort the run if it goes past the cycle limit
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [31:0] rot_left(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Run the 80 rounds over the buffered block and fold into the chaining value
    function automatic void run_rounds();
        logic [31:0] w [16];
        work_t v;
        logic [31:0] f;
        logic [31:0] k;
        logic [31:0] t;
        for (int r = 0; r < 16; r++)
        begin
            w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2],
                    block_bytes[4*r+3]};
        end
        v = chain;
        for (int r = 0; r < 80; r++)
        begin
            if (r >= 16)
            begin
                w[r % 16] = rot_left(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^
                                     w[(r + 2) % 16] ^ w[r % 16], 1);
            end
            if (r < 20)
            begin
                f = (v.b & v.c) | (~v.b & v.d);
                k = K_CHOOSE;
            end
            else if (r < 40)
            begin
                f = v.b ^ v.c ^ v.d;
                k = K_PARITY_LO;
            end
            else if (r < 60)
            begin
                f = (v.b & v.c) | (v.b & v.d) | (v.c & v.d);
                k = K_MAJORITY;
            end
            else
            begin
                f = v.b ^ v.c ^ v.d;
                k = K_PARITY_HI;
            end
            t = rot_left(v.a, 5) + f + v.e + k + w[r % 16];
            v.e = v.d;
            v.d = v.c;
            v.c = rot_left(v.b, 30);
            v.b = v.a;
            v.a = t;
        end
        chain.a = chain.a + v.a;
        chain.b = chain.b + v.b;
        chain.c = chain.c + v.c;
        chain.d = chain.d + v.d;
        chain.e = chain.e + v.e;
    endfunction

    // Place one byte big-endian in the block; compress when the block fills
    function automatic void absorb_byte(input logic [7:0] b);
        logic [5:0] pos;
        pos = byte_count[5:0];
        block_bytes[pos] = b;
        byte_count = byte_count + 64'd1;
        if (pos == 6'd63)
        begin
            run_rounds();
        end
    endfunction

    // Pad, append the bit length, queue the digest and restart the message
    function automatic void close_message();
        logic [63:0] bit_len;
        dig_item_t d;
        bit_len = byte_count << 3;
        absorb_byte(PAD_MARK);
        while (byte_count[5:0] != LEN_OFFSET)
        begin
            absorb_byte(8'h00);
        end
        for (int i = 7; i >= 0; i--)
        begin
            absorb_byte(bit_len[8*i +: 8]);
        end
        d.digest_word_0 = chain.a;
        d.digest_word_1 = chain.b;
        d.digest_word_2 = chain.c;
        d.digest_word_3 = chain.d;
        d.digest_word_4 = chain.e;
        pending_digests.push_back(d);
        chain = CV_INIT;
        byte_count = '0;
    endfunction

    function automatic void hash_item(input msg_item_t it);
        if (it.req_type == REQ_APPEND)
        begin
            absorb_byte(it.message_byte);
        end
        else
        begin
            close_message();
        end
    endfunction

    task automatic report_mismatch(input string what, input int idx,
                                   input logic [31:0] got, input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("MISMATCH cycle %0d: %s %0d got %08h expected %08h",
                     cycle_count, what, idx, got, want);
        end
    endtask

    // Compare one digest transaction, word by word, with the oldest prediction
    task automatic check_digest(input dig_item_t got);
        dig_item_t want;
        logic [159:0] got_bits;
        logic [159:0] want_bits;
        if (pending_digests.size() == 0)
        begin
            report_mismatch("unexpected digest, word", 0, got.digest_word_0, 32'h0);
        end
        else
        begin
            want = pending_digests.pop_front();
            got_bits = got;
            want_bits = want;
            for (int i = 0; i < 5; i++)
            begin
                if (got_bits[159 - 32*i -: 32] !== want_bits[159 - 32*i -: 32])
                begin
                    report_mismatch("digest word", i, got_bits[159 - 32*i -: 32],
                                    want_bits[159 - 32*i -: 32]);
                end
            end
            digests_checked++;
        end
    endtask

    // Sample the output handshake mid-cycle, where everything has settled
    always @(negedge clk)
    begin
        if (rst_n && dig_valid && !dig_stall)
        begin
            check_digest(dig_item);
        end
    end

    // Drive the output stall: random, or held high during a hold-off
    initial
    begin : receiver_stall
        dig_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            dig_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic hold_receiver(input int cycles);
        hold_off <= 1'b1;
        repeat (cycles) @(posedge clk);
        hold_off <= 1'b0;
    endtask

    // Offer one transaction and hold it until the block takes it
    task automatic send_item(input msg_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            msg_valid <= 1'b0;
            @(posedge clk);
        end
        msg_valid <= 1'b1;
        msg_item <= it;
        @(negedge clk);
        while (msg_stall)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        items_sent++;
        hash_item(it);
    endtask

    function automatic msg_item_t make_item(input logic req, input logic [7:0] b);
        msg_item_t it;
        it.req_type = req;
        it.message_byte = b;
        return it;
    endfunction

    task automatic send_bytes(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_item(make_item(REQ_APPEND, 8'($urandom_range(255))));
        end
    endtask

    task automatic send_message(input int len);
        send_bytes(len);
        send_item(make_item(REQ_FINISH, 8'($urandom_range(255))));
    endtask

    // Drop valid and wait until every predicted digest has come out
    task automatic wait_for_digests();
        msg_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_digests.size() != 0);
    endtask

    // Mostly short messages, a share near the padding and block edges, a few long
    function automatic int pick_length();
        int roll;
        int len;
        roll = $urandom_range(99);
        if (roll < 65)
        begin
            len = $urandom_range(40);
        end
        else if (roll < 75)
        begin
            len = 64 * $urandom_range(1, 2) - 9 + $urandom_range(2);
        end
        else if (roll < 85)
        begin
            len = 64 * $urandom_range(1, 2) - 1 + $urandom_range(2);
        end
        else
        begin
            len = $urandom_range(41, 150);
        end
        return len;
    endfunction

    // Empty message, a short text, byte extremes, a byte equal to the pad mark
    task automatic test_directed_vectors();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_item(make_item(REQ_FINISH, 8'h00));
        send_item(make_item(REQ_APPEND, 8'h61));
        send_item(make_item(REQ_APPEND, 8'h62));
        send_item(make_item(REQ_APPEND, 8'h63));
        send_item(make_item(REQ_FINISH, 8'hFF));
        send_item(make_item(REQ_APPEND, 8'h00));
        send_item(make_item(REQ_FINISH, 8'h00));
        send_item(make_item(REQ_APPEND, 8'hFF));
        send_item(make_item(REQ_FINISH, 8'hFF));
        send_item(make_item(REQ_APPEND, PAD_MARK));
        send_item(make_item(REQ_FINISH, 8'h00));
        send_item(make_item(REQ_FINISH, 8'hA5));
        wait_for_digests();
    endtask

    // Lengths where the padding fits in one block or spills into a second
    task automatic test_padding_boundaries();
        int lens [8];
        lens = '{55, 56, 57, 63, 64, 65, 119, 120};
        send_idle_pct = 24;
        recv_stall_pct = 24;
        foreach (lens[i])
        begin
            send_message(lens[i]);
        end
        wait_for_digests();
    endtask

    task automatic test_random_messages(input int idle_pct, input int stall_pct,
                                        input int quota);
        int start;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        start = items_sent;
        while (items_sent - start < quota)
        begin
            send_message(pick_length());
        end
        wait_for_digests();
    endtask

    // Hold the output off while short messages keep coming, so the block backs up
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            hold_receiver(600);
            begin
                for (int m = 0; m < 16; m++)
                begin
                    send_message($urandom_range(4, 12));
                end
            end
        join
        wait_for_digests();
    endtask

    // Stop mid-message until all digests are out, then finish the message
    task automatic test_pause_mid_message();
        send_idle_pct = 24;
        recv_stall_pct = 24;
        repeat (3)
        begin
            send_message($urandom_range(30));
            send_bytes($urandom_range(40, 80));
            wait_for_digests();
            send_message($urandom_range(30));
        end
        wait_for_digests();
    endtask

    initial
    begin : main_sequence
        rst_n <= 1'b0;
        msg_valid <= 1'b0;
        msg_item <= '0;
        chain = CV_INIT;
        byte_count = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_vectors();
        test_padding_boundaries();
        test_random_messages(0, 0, 150);
        test_random_messages(72, 0, 150);
        test_random_messages(0, 72, 150);
        test_random_messages(24, 24, 150);
        test_output_backpressure();
        test_pause_mid_message();

        // Let any stray output show up before closing
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_digests.size() != 0)
        begin
            report_mismatch("digests never delivered, count", pending_digests.size(),
                            32'h0, 32'h0);
        end

        $display("Sent %0d message transactions and checked %0d digests", items_sent,
                 digests_checked);
        $display("Covered empty and boundary lengths, idle and stall mixes, output hold-off");
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
